@@ hdl/gha_pkg.sv @@
`timescale 1ns / 1ps

package gha_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int HALF_BITS   = 64;
  localparam int GF_BITS     = 128;
  localparam int COUNT_BITS  = 61;
  localparam int NBYTES_BITS = 5;

  localparam logic [1:0] OP_AAD    = 2'd0;
  localparam logic [1:0] OP_CIPHER = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [HALF_BITS-1:0]   block_high;
    logic [HALF_BITS-1:0]   block_low;
    logic [NBYTES_BITS-1:0] valid_bytes;
  } in_word_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] digest_high;
    logic [HALF_BITS-1:0] digest_low;
  } out_word_t;

endpackage

@@ hdl/gha_gfmul.sv @@
`timescale 1ns / 1ps

module gha_gfmul import gha_pkg::*; (
  input  logic [GF_BITS-1:0] x,
  input  logic [GF_BITS-1:0] h,
  output logic [GF_BITS-1:0] z
);

  logic [GF_BITS-1:0]     xp;
  logic [GF_BITS-1:0]     hp;
  logic [2*GF_BITS-2:0]   prod;
  logic [GF_BITS-2:0]     hi;
  logic [GF_BITS+5:0]     fold1;
  logic [5:0]             hi2;
  logic [12:0]            fold2;
  logic [GF_BITS-1:0]     zp;

  // GCM bit order: first bit of the word is the constant term
  always_comb begin
    for (int d = 0; d < GF_BITS; d++) begin
      xp[d] = x[GF_BITS-1-d];
      hp[d] = h[GF_BITS-1-d];
    end
  end

  // carryless product
  always_comb begin
    prod = '0;
    for (int i = 0; i < GF_BITS; i++) begin
      if (xp[i]) begin
        prod = prod ^ ({{(GF_BITS-1){1'b0}}, hp} << i);
      end
    end
  end

  // reduce by x^128 + x^7 + x^2 + x + 1 in two folds
  always_comb begin
    hi    = prod[2*GF_BITS-2:GF_BITS];
    fold1 = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
    hi2   = fold1[GF_BITS+5:GF_BITS];
    fold2 = {7'b0, hi2} ^ {6'b0, hi2, 1'b0} ^ {5'b0, hi2, 2'b0} ^ {hi2, 7'b0};
    zp    = prod[GF_BITS-1:0] ^ fold1[GF_BITS-1:0] ^ {{(GF_BITS-13){1'b0}}, fold2};
    for (int d = 0; d < GF_BITS; d++) begin
      z[GF_BITS-1-d] = zp[d];
    end
  end

endmodule

@@ hdl/ghash_authenticator_top.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   in_data  (in_word_t)
// out_     output     out_valid / out_ready out_data (out_word_t)
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One word per cycle while no finish word is held: a word is registered in the
// input register, then the combinational GF(2^128) multiply updates the
// accumulator; finish sets out_valid from the output register. Synchronous
// active-low reset clears key, accumulator and counters. A finish word waits in
// the input register only while the output register holds an untaken digest.

module ghash_authenticator_top import gha_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [HALF_BITS-1:0] cfg_wdata
);

  logic [HALF_BITS-1:0]  key_high_r;
  logic [HALF_BITS-1:0]  key_low_r;
  logic                  in_vld_r;
  in_word_t              in_word_r;
  logic [GF_BITS-1:0]    acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] aad_cnt_r, aad_cnt_nxt;
  logic [COUNT_BITS-1:0] ct_cnt_r, ct_cnt_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                   proc_ok;
  logic                   consume;
  logic [NBYTES_BITS-1:0] nbytes;
  logic [GF_BITS-1:0]     block;
  logic [GF_BITS-1:0]     mul_in;
  logic [GF_BITS-1:0]     mul_out;

  assign proc_ok  = (in_word_r.opcode != OP_FINISH) || !out_vld_r || out_ready;
  assign consume  = in_vld_r && proc_ok;
  assign in_ready = !in_vld_r || proc_ok;

  // saturate and mask trailing bytes
  always_comb begin
    nbytes = (in_word_r.valid_bytes > NBYTES_BITS'(BLOCK_BYTES)) ?
             NBYTES_BITS'(BLOCK_BYTES) : in_word_r.valid_bytes;
    block  = {in_word_r.block_high, in_word_r.block_low};
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      if (NBYTES_BITS'(b) >= nbytes) begin
        block[GF_BITS-1-8*b -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (in_word_r.opcode == OP_FINISH) begin
      mul_in = acc_r ^ {aad_cnt_r, 3'b000, ct_cnt_r, 3'b000};
    end else begin
      mul_in = acc_r ^ block;
    end
  end

  gha_gfmul u_gfmul (
    .x (mul_in),
    .h ({key_high_r, key_low_r}),
    .z (mul_out)
  );

  always_comb begin
    acc_nxt      = acc_r;
    aad_cnt_nxt  = aad_cnt_r;
    ct_cnt_nxt   = ct_cnt_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_word_nxt = out_word_r;
    if (consume) begin
      case (in_word_r.opcode)
        OP_AAD: begin
          if (nbytes != '0) begin
            acc_nxt     = mul_out;
            aad_cnt_nxt = aad_cnt_r + COUNT_BITS'(nbytes);
          end
        end
        OP_CIPHER: begin
          if (nbytes != '0) begin
            acc_nxt    = mul_out;
            ct_cnt_nxt = ct_cnt_r + COUNT_BITS'(nbytes);
          end
        end
        OP_FINISH: begin
          acc_nxt      = '0;
          aad_cnt_nxt  = '0;
          ct_cnt_nxt   = '0;
          out_vld_nxt  = 1'b1;
          out_word_nxt = {mul_out[GF_BITS-1:HALF_BITS], mul_out[HALF_BITS-1:0]};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      in_vld_r   <= 1'b0;
      acc_r      <= '0;
      aad_cnt_r  <= '0;
      ct_cnt_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_HIGH) begin
          key_high_r <= cfg_wdata;
        end
        if (cfg_index == CFG_KEY_LOW) begin
          key_low_r <= cfg_wdata;
        end
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      acc_r     <= acc_nxt;
      aad_cnt_r <= aad_cnt_nxt;
      ct_cnt_r  <= ct_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule
